// ----- rtl/core/desc_pkg.sv -----
// Shared types and constants for the debounced event session counter.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package desc_pkg;

   localparam int TIME_W     = 56;
   localparam int COUNT_W    = 16;
   localparam int DEBOUNCE_W = 8;
   localparam int SECONDS_W  = 16;
   localparam int PRESCALE_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SECONDS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 2'd2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd30;
   localparam logic [SECONDS_W-1:0]  IDLE_RESET     = 16'd60;
   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd1000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // command field codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic              command;
      logic              pin_level;
      logic [TIME_W-1:0] time_now;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] live_count;
      logic               record_valid;
      logic [TIME_W-1:0]  record_start;
      logic [TIME_W-1:0]  record_end;
      logic [COUNT_W-1:0] record_count;
   } rsp_type;

endpackage

// ----- rtl/core/desc_qualifier.sv -----
// Falling-edge qualifier with debounce delay for the session counter.
// Depends on desc_pkg.
module desc_qualifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             pin_level,
   input  logic [desc_pkg::DEBOUNCE_W-1:0]  debounce_ticks,
   output logic                             hit
);

   logic                            prev_ff, prev_in;
   logic                            busy_ff, busy_in;
   logic [desc_pkg::DEBOUNCE_W-1:0] left_ff, left_in;
   logic [desc_pkg::DEBOUNCE_W-1:0] left_dec;
   logic                            expire;

   always_comb begin
      left_dec = (left_ff != '0) ? left_ff - 1'b1 : '0;
      expire   = busy_ff && (left_dec == '0);
      hit      = expire && !pin_level;
      prev_in  = pin_level;
      busy_in  = busy_ff;
      left_in  = left_ff;
      if (busy_ff) begin
         left_in = left_dec;
         busy_in = !expire;
      end else if (prev_ff && !pin_level) begin
         busy_in = 1'b1;
         // zero delay behaves as one tick
         left_in = (debounce_ticks == '0) ? {{(desc_pkg::DEBOUNCE_W-1){1'b0}}, 1'b1}
                                          : debounce_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b1;
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else if (step) begin
         prev_ff <= prev_in;
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
   end

endmodule

// ----- rtl/core/debounced_event_session_counter_top.sv -----
// Debounced event session counter, top level.
// Depends on desc_pkg and desc_qualifier.
//
// Usage:
//   req channel: one transfer per item, either a tick (command = tick) carrying
//   the pin level and timestamp, or a clear-count command.
//   rsp channel: exactly one transfer per request, in order, carrying the live
//   count and, when an idle timeout expires, the finished session record.
//   csr port: single-cycle writes of debounce_ticks, idle_seconds and
//   ticks_per_second; write only while no request is outstanding.
// Timing: a request is registered in the input register, then evaluated into the
//   result register that drives rsp_valid and rsp_data.
//   Throughput is one item per clock while no response is held, set by the
//   single evaluate stage between the input and result registers.
// Reset: synchronous, clears both stages, all counters and the session, and
//   restores register defaults (30, 60, 1000).
// Stall: a held response freezes the evaluate stage; the input register still
//   takes one more request, after which req_ready drops until rsp_ready returns.
module debounced_event_session_counter_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  desc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output desc_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [desc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [desc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = desc_pkg::COUNT_W;
   localparam int PW = desc_pkg::PRESCALE_W;
   localparam int SW = desc_pkg::SECONDS_W;
   localparam int TW = desc_pkg::TIME_W;

   // configuration
   logic [desc_pkg::DEBOUNCE_W-1:0] dbt_ff;
   logic [SW-1:0]                   idle_cfg_ff;
   logic [PW-1:0]                   tps_ff;

   // pipeline
   logic              in_valid_ff, in_valid_in;
   desc_pkg::req_type in_data_ff;
   logic              rsp_valid_ff;
   desc_pkg::rsp_type rsp_data_ff, rsp_in;
   logic              advance, take, tick, req_fire;

   // session state
   logic [PW-1:0] prescale_ff, prescale_in;
   logic [SW-1:0] idle_ff, idle_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] start_ff, start_in;

   logic          hit;
   logic [CW-1:0] count_ev;
   logic [SW-1:0] idle_ev;
   logic [PW-1:0] period;
   logic [PW:0]   next_ps;
   logic          second, fire;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign take        = in_valid_ff && advance;
   assign tick        = take && (in_data_ff.command == desc_pkg::CMD_TICK);
   assign req_ready   = !in_valid_ff || advance;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   desc_qualifier u_qualifier (
      .clock          (clock),
      .reset          (reset),
      .step           (tick),
      .pin_level      (in_data_ff.pin_level),
      .debounce_ticks (dbt_ff),
      .hit            (hit)
   );

   always_comb begin
      // event first, then the seconds prescaler sees the reloaded timeout
      count_ev = count_ff;
      idle_ev  = idle_ff;
      start_in = start_ff;
      if (hit) begin
         if (count_ff == '0) start_in = in_data_ff.time_now;
         if (count_ff != desc_pkg::COUNT_MAX) count_ev = count_ff + 1'b1;
         idle_ev = idle_cfg_ff;
      end

      period  = (tps_ff == '0) ? {{(PW-1){1'b0}}, 1'b1} : tps_ff;
      next_ps = {1'b0, prescale_ff} + 1'b1;
      second  = next_ps >= {1'b0, period};
      prescale_in = second ? '0 : next_ps[PW-1:0];

      fire    = second && (idle_ev == {{(SW-1){1'b0}}, 1'b1});
      idle_in = (second && idle_ev != '0) ? idle_ev - 1'b1 : idle_ev;
      count_in = fire ? '0 : count_ev;

      rsp_in.live_count   = count_in;
      rsp_in.record_valid = fire;
      rsp_in.record_start = fire ? start_in : '0;
      rsp_in.record_end   = fire ? in_data_ff.time_now : '0;
      rsp_in.record_count = fire ? count_ev : '0;

      if (in_data_ff.command == desc_pkg::CMD_CLEAR) begin
         rsp_in              = '0;
         rsp_in.live_count   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbt_ff      <= desc_pkg::DEBOUNCE_RESET;
         idle_cfg_ff <= desc_pkg::IDLE_RESET;
         tps_ff      <= desc_pkg::PRESCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            desc_pkg::CSR_DEBOUNCE_TICKS:   dbt_ff      <= csr_wdata[desc_pkg::DEBOUNCE_W-1:0];
            desc_pkg::CSR_IDLE_SECONDS:     idle_cfg_ff <= csr_wdata[SW-1:0];
            desc_pkg::CSR_TICKS_PER_SECOND: tps_ff      <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prescale_ff  <= '0;
         idle_ff      <= '0;
         count_ff     <= '0;
         start_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) rsp_valid_ff <= take;
         if (tick) begin
            prescale_ff <= prescale_in;
            idle_ff     <= idle_in;
            count_ff    <= count_in;
            start_ff    <= start_in;
         end else if (take) begin
            // clear command touches only the count
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) in_data_ff <= req_data;
      if (take) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/desc_checker.sv -----
// Port-level checks for the session counter top, attached by bind.
// Depends on desc_pkg and debounced_event_session_counter_top.
module desc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input desc_pkg::rsp_type rsp_data
);

   // a stalled transfer holds its response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // emitting a record always empties the session count
   a_record_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_valid |-> rsp_data.live_count == '0)
      else $error("count not cleared with record");

   a_record_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.record_valid |->
         rsp_data.record_start == '0 && rsp_data.record_end == '0 &&
         rsp_data.record_count == '0)
      else $error("record fields set without record");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

endmodule

bind debounced_event_session_counter_top desc_checker u_desc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/desc_session_checker.sv -----
// Checker for the debounced event session counter: watches req/rsp/csr and predicts every response.
// Depends on desc_pkg for the payload types, register indexes and reset values.
`timescale 1ns / 100ps

module desc_session_checker
   import desc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   // shadow registers
   logic [DEBOUNCE_W-1:0] cfg_debounce;
   logic [SECONDS_W-1:0]  cfg_idle;
   logic [PRESCALE_W-1:0] cfg_tps;

   // session state
   logic                  last_level;
   logic                  qual_busy;
   logic [DEBOUNCE_W-1:0] debounce_left;
   logic [PRESCALE_W-1:0] prescale;
   logic [SECONDS_W-1:0]  idle_left;
   logic [COUNT_W-1:0]    event_count;
   logic [TIME_W-1:0]     session_start;

   rsp_type session_updates[$];
   int      mismatches = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic rsp_type advance_session(input req_type item);
      rsp_type           res;
      logic [PRESCALE_W:0] next_prescale;
      logic [PRESCALE_W-1:0] period;
      res = '0;
      if (item.command == CMD_CLEAR) begin
         event_count = '0;
      end else begin
         if (qual_busy) begin
            if (debounce_left != '0) debounce_left = debounce_left - 1'b1;
            if (debounce_left == '0) begin
               qual_busy = 1'b0;
               if (!item.pin_level) begin
                  if (event_count == '0) session_start = item.time_now;
                  if (event_count != COUNT_MAX) event_count = event_count + 1'b1;
                  idle_left = cfg_idle;
               end
            end
         end else if (last_level && !item.pin_level) begin
            qual_busy     = 1'b1;
            debounce_left = (cfg_debounce == '0) ? DEBOUNCE_W'(1) : cfg_debounce;
         end
         last_level = item.pin_level;

         // seconds prescaler runs after the qualifier on every tick
         period        = (cfg_tps == '0) ? PRESCALE_W'(1) : cfg_tps;
         next_prescale = {1'b0, prescale} + 1'b1;
         if (next_prescale >= {1'b0, period}) begin
            prescale = '0;
            if (idle_left != '0) begin
               idle_left = idle_left - 1'b1;
               if (idle_left == '0) begin
                  res.record_valid = 1'b1;
                  res.record_start = session_start;
                  res.record_end   = item.time_now;
                  res.record_count = event_count;
                  event_count      = '0;
               end
            end
         end else begin
            prescale = next_prescale[PRESCALE_W-1:0];
         end
      end
      res.live_count = event_count;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_debounce  = DEBOUNCE_RESET;
         cfg_idle      = IDLE_RESET;
         cfg_tps       = PRESCALE_RESET;
         last_level    = 1'b1;
         qual_busy     = 1'b0;
         debounce_left = '0;
         prescale      = '0;
         idle_left     = '0;
         event_count   = '0;
         session_start = '0;
         session_updates.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS:   cfg_debounce = csr_wdata[DEBOUNCE_W-1:0];
               CSR_IDLE_SECONDS:     cfg_idle     = csr_wdata[SECONDS_W-1:0];
               CSR_TICKS_PER_SECOND: cfg_tps      = csr_wdata[PRESCALE_W-1:0];
               default: ;
            endcase
         end
         // check the response before queueing this edge's request
         if (rsp_valid && rsp_ready) begin
            if (session_updates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transfer: count %0d valid %0b",
                           rsp_data.live_count, rsp_data.record_valid);
            end else begin
               want = session_updates.pop_front();
               if (rsp_data.live_count   !== want.live_count   ||
                   rsp_data.record_valid !== want.record_valid ||
                   rsp_data.record_start !== want.record_start ||
                   rsp_data.record_end   !== want.record_end   ||
                   rsp_data.record_count !== want.record_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch exp: count %0d valid %0b start %h end %h n %0d",
                              want.live_count, want.record_valid, want.record_start,
                              want.record_end, want.record_count);
                     $display("         got: count %0d valid %0b start %h end %h n %0d",
                              rsp_data.live_count, rsp_data.record_valid,
                              rsp_data.record_start, rsp_data.record_end,
                              rsp_data.record_count);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            session_updates.push_back(advance_session(req_data));
      end
      fail_count  <= mismatches;
      outstanding <= session_updates.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the session counter testbench: clock, reset, stimulus phases and the verdict.
// Depends on desc_pkg, debounced_event_session_counter_top and desc_session_checker.
`timescale 1ns / 100ps

module tb_top;
   import desc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int STALL_LIMIT = 5000;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   int quiet_cycles = 0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cur_debounce  = int'(DEBOUNCE_RESET);
   int cur_idle      = int'(IDLE_RESET);
   int cur_tps       = int'(PRESCALE_RESET);

   debounced_event_session_counter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   desc_session_checker session_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] random_stamp();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return TIME_W'({$urandom, $urandom});
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 88; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 88; end
         default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
   endtask

   // returns at the edge where the item transfers; valid stays high for back-to-back items
   task automatic offer_item(input logic cmd, input logic pin, input logic [TIME_W-1:0] stamp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_data.command   <= cmd;
      req_data.pin_level <= pin;
      req_data.time_now  <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic tick(input logic pin);
      offer_item(CMD_TICK, pin, random_stamp());
   endtask

   // hold off until every response is back, plus pipeline slack
   task automatic settle;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input int deb, input int idle_s, input int tps);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE_TICKS;
      csr_wdata <= {8'($urandom_range(255)), 8'(deb)};
      @(posedge clock);
      csr_index <= CSR_IDLE_SECONDS;
      csr_wdata <= 16'(idle_s);
      @(posedge clock);
      csr_index <= CSR_TICKS_PER_SECOND;
      csr_wdata <= 16'(tps);
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we       <= 1'b0;
      cur_debounce = deb;
      cur_idle     = idle_s;
      cur_tps      = tps;
   endtask

   task automatic run_traffic(input int n_items);
      int sent;
      int eff_deb;
      int quiet_max;
      int pick;
      sent      = 0;
      eff_deb   = (cur_debounce == 0) ? 1 : cur_debounce;
      quiet_max = cur_idle * ((cur_tps == 0) ? 1 : cur_tps) + 2;
      if (quiet_max > 64) quiet_max = 64;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // clean press: high, then low long enough to qualify most of the time
            repeat ($urandom_range(1, 3)) begin
               tick(1'b1);
               sent++;
            end
            repeat (eff_deb + $urandom_range(0, 3)) begin
               tick(1'b0);
               sent++;
            end
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) begin
               tick(1'($urandom));
               sent++;
            end
         end else if (pick < 82) begin
            offer_item(CMD_CLEAR, 1'($urandom), random_stamp());
            sent++;
         end else begin
            // quiet stretch so the idle timeout can run out
            repeat ($urandom_range(1, quiet_max)) begin
               tick(1'b1);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: edge starts a long debounce, clears ignore pin and time
      offer_item(CMD_TICK, 1'b1, '0);
      offer_item(CMD_TICK, 1'b0, '1);
      offer_item(CMD_CLEAR, 1'b0, random_stamp());
      offer_item(CMD_CLEAR, 1'b1, '1);
      tick(1'b0);
      settle;

      // zero debounce and zero prescale both behave as one
      configure(0, 2, 0);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
      tick(1'b1);
      tick(1'b0);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
      offer_item(CMD_CLEAR, 1'b0, random_stamp());
      tick(1'b1);
      tick(1'b1);
      settle;

      // zero idle: events count but no record follows
      configure(1, 0, 1);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
      tick(1'b1);
      tick(1'b1);
      settle;

      // prescaler runs up under a long period, then the period drops below it
      configure(3, 1, 65535);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
      tick(1'b0);
      tick(1'b0);
      tick(1'b1);
      settle;
      configure(3, 1, 2);
      tick(1'b1);
      settle;

      configure(1, 1, 1);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
      tick(1'b1);
      settle;

      for (int phase = 0; phase < 12; phase++) begin
         set_idling(phase % 4);
         if (phase == 5)
            configure(255, 65535, 65535);
         else if (phase == 9)
            configure(255, 1, 1);
         else
            configure($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 5));
         run_traffic(25);
         settle;
      end

      if (fail_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
